[design/fbac_pkg.sv]
// fbac_pkg: shared widths, reset constants and CSR index constants
// used by the alpha compositor front, back and top level; no dependencies
`default_nettype none
package fbac_pkg;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DEPTH_BITS_DEF = 32;
   localparam int SPLIT_BITS     = 24;
   localparam int CFG_IDX_BITS   = 1;
   localparam logic [CFG_IDX_BITS-1:0] CFG_OPACITY_CUTOFF = 1'b0;
   localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_STOP     = 1'b1;
   localparam int CUTOFF_RESET = 257;
   localparam int STOP_RESET   = 65470;
endpackage
`default_nettype wire

[design/fbac_if.sv]
// fbac_if: valid/ready channel carrying a packed payload
// depends on nothing
`default_nettype none
interface fbac_if #(parameter int W = 8) (input wire logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/fbac_front.sv]
// fbac_front: accepts hits, saturates fields and pushes them into a 2-entry queue
// depends on fbac_pkg
`default_nettype none
module fbac_front import fbac_pkg::*; #(
   parameter int FB = FRAC_BITS_DEF,
   parameter int DB = DEPTH_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic [4*(FB+1)+DB:0] in_data,
   output logic      q_valid,
   input  wire logic q_pop,
   output logic [4*(FB+1)+DB:0] q_data
);
   localparam int W = 4*(FB+1)+DB+1;
   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [W-1:0] sat;
   logic         push;
   function automatic logic [FB:0] s1(input logic [FB:0] v);
      return (v > ONE) ? ONE : v;
   endfunction
   always_comb begin
      sat = in_data;
      sat[W-1 -: FB+1]        = s1(in_data[W-1 -: FB+1]);
      sat[W-1-(FB+1) -: FB+1] = s1(in_data[W-1-(FB+1) -: FB+1]);
      sat[W-1-2*(FB+1) -: FB+1] = s1(in_data[W-1-2*(FB+1) -: FB+1]);
      sat[W-1-3*(FB+1) -: FB+1] = s1(in_data[W-1-3*(FB+1) -: FB+1]);
   end
   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= sat;
   end
endmodule
`default_nettype wire

[design/fbac_back.sv]
// fbac_back: sequencer with one shared multiplier and a serial divider that
// accumulates hits and forms the result; depends on fbac_pkg
`default_nettype none
module fbac_back import fbac_pkg::*; #(
   parameter int FB = FRAC_BITS_DEF,
   parameter int DB = DEPTH_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [FB-1:0] cutoff,
   input  wire logic [FB:0]   stop,
   input  wire logic q_valid,
   output logic      q_pop,
   input  wire logic [4*(FB+1)+DB:0] q_data,
   output logic      out_valid,
   input  wire logic out_ready,
   output logic [4*(FB+1)+DB:0] out_data
);
   localparam int V  = FB+1;
   localparam int SB = FB+8;
   localparam int HB = DB+V+2;          // high part of depth sum
   localparam int WB = FB+2;
   localparam int DW = HB+SB;
   localparam int CW = $clog2(DW+2);
   localparam int MW = (DB > V ? DB : V);
   localparam logic [V-1:0] ONE = {1'b1, {FB{1'b0}}};
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_CTB = 8'b00000010, S_R = 8'b00000100,
      S_G = 8'b00001000, S_B = 8'b00010000, S_DL = 8'b00100000,
      S_DH = 8'b01000000, S_DIV = 8'b10000000
   } state_type;
   state_type st_ff, st_in;
   logic [FB+5:0] ar_ff, ag_ff, ab_ff;
   logic [V-1:0]  t_ff, ctb_ff;
   logic [HB-1:0] dh_ff;
   logic [SB-1:0] dl_ff;
   logic [WB-1:0] w_ff;
   logic [DB-1:0] fd_ff;
   logic          open_ff;
   logic [4*V+DB:0] h_ff;
   logic [V-1:0]  a, r, g, b;
   logic [DB-1:0] d;
   logic          last;
   logic [MW-1:0] ma;
   logic [V-1:0]  mb;
   logic [MW+V-1:0] prod;
   logic [V-1:0]  rnd;
   logic [DW-1:0] num_ff;
   logic [WB:0]   rem_ff;
   logic [CW-1:0] cnt_ff;
   logic [WB:0]   rs;
   logic          ov_ff;
   logic [4*V+DB:0] od_ff;
   logic [V-1:0]  t0;
   logic          act;
   logic [SB:0]   lsum;
   logic [HB+SB:0] tot;
   assign {a, r, g, b, d, last} = h_ff;
   assign t0  = open_ff ? t_ff : ONE;
   assign act = (t0 > (ONE - ((stop > ONE) ? ONE : stop))) && (a >= {1'b0, cutoff});
   always_comb begin
      ma = '0; mb = ctb_ff;
      unique case (st_ff)
         S_CTB:   begin ma = MW'(a); mb = t0; end
         S_R:     ma = MW'(r);
         S_G:     ma = MW'(g);
         S_B:     ma = MW'(b);
         S_DL:    ma = MW'(d[(DB>SB?SB:DB)-1:0]);
         S_DH:    ma = MW'(d >> SB);
         default: ma = '0;
      endcase
   end
   assign prod = ma * mb;
   assign rnd  = V'((prod + (MW+V)'(ONE >> 1)) >> FB);
   assign lsum = {1'b0, dl_ff} + (SB+1)'(w_ff >> 1);
   assign tot  = {(HB+SB+1)'(dh_ff + HB'(lsum[SB])) << SB} | (HB+SB+1)'(lsum[SB-1:0]);
   assign rs   = {rem_ff[WB-1:0], num_ff[DW-1]};
   assign q_pop = (st_ff == S_IDLE) && q_valid;
   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   function automatic logic [V-1:0] s1(input logic [FB+5:0] v);
      return (v > (FB+6)'(ONE)) ? ONE : V'(v);
   endfunction
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (q_pop) st_in = S_CTB;
         S_CTB:  st_in = act ? S_R : S_DIV;
         S_R:    st_in = S_G;
         S_G:    st_in = S_B;
         S_B:    st_in = S_DL;
         S_DL:   st_in = S_DH;
         S_DH:   st_in = S_DIV;
         S_DIV:  if (!last || (cnt_ff == '0 && !ov_ff)) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; open_ff <= 1'b0; ov_ff <= 1'b0;
         t_ff <= ONE; ar_ff <= '0; ag_ff <= '0; ab_ff <= '0;
         dh_ff <= '0; dl_ff <= '0; w_ff <= '0; fd_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (q_pop) h_ff <= q_data;
            S_CTB: begin
               if (!open_ff) begin
                  ar_ff <= '0; ag_ff <= '0; ab_ff <= '0; t_ff <= ONE;
                  dh_ff <= '0; dl_ff <= '0; w_ff <= '0; fd_ff <= d; open_ff <= 1'b1;
               end
               ctb_ff <= (rnd > t0) ? t0 : rnd;
               cnt_ff <= CW'(DW+1);
            end
            S_R: ar_ff <= ar_ff + (FB+6)'(rnd);
            S_G: ag_ff <= ag_ff + (FB+6)'(rnd);
            S_B: begin
               ab_ff <= ab_ff + (FB+6)'(rnd);
               w_ff  <= w_ff + WB'(ctb_ff);
               t_ff  <= t_ff - ctb_ff;
            end
            S_DL: begin
               dl_ff <= SB'(dl_ff + SB'(prod));
               dh_ff <= dh_ff + HB'((SB+V+1)'(dl_ff) + (SB+V+1)'(prod) >> SB);
            end
            S_DH: dh_ff <= dh_ff + HB'(prod);
            S_DIV: if (last) begin
               if (cnt_ff == CW'(DW+1)) begin
                  num_ff <= DW'(tot); rem_ff <= '0; cnt_ff <= cnt_ff - 1'b1;
               end else if (cnt_ff != '0) begin
                  if (rs >= {1'b0, w_ff}) begin
                     rem_ff <= rs - {1'b0, w_ff}; num_ff <= {num_ff[DW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rs; num_ff <= {num_ff[DW-2:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 1'b1;
               end else if (!ov_ff) begin
                  ov_ff <= 1'b1; open_ff <= 1'b0;
                  if ((ONE - t_ff) >= {1'b0, cutoff})
                     od_ff <= {s1(ar_ff), s1(ag_ff), s1(ab_ff), t_ff,
                               (w_ff == '0) ? fd_ff : num_ff[DB-1:0], 1'b1};
                  else
                     od_ff <= {{3*V{1'b0}}, ONE, {DB{1'b0}}, 1'b0};
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

[design/front_to_back_alpha_compositor_unit.sv]
// Front-to-back alpha compositor. A hit that contributes steps through S_CTB, S_R, S_G,
// S_B, S_DL, S_DH and S_DIV in the back sequencer (one shared 32x17 multiplier, one
// product per cycle); a skipped or stopped hit goes from S_CTB straight to S_DIV. The
// last hit of a ray stays in S_DIV for a restoring divide, one quotient bit per cycle,
// for the mean depth. A 2-entry queue sits in front; a finished result waits in an output
// register while the next hit is taken, and the next result waits for it to be accepted.
// depends on fbac_pkg, fbac_if, fbac_front, fbac_back
`default_nettype none
module front_to_back_alpha_compositor_unit import fbac_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   fbac_if.sink     req,
   fbac_if.source   rsp,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [CFG_IDX_BITS-1:0] csr_index,
   input  wire logic [FRAC_BITS:0]      csr_data
);
   localparam int W = 4*(FRAC_BITS+1)+DEPTH_BITS+1;
   logic [FRAC_BITS-1:0] cut_ff;
   logic [FRAC_BITS:0]   stop_ff;
   logic qv, qp;
   logic [W-1:0] qd;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff  <= FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd127) / 64'd255);
         stop_ff <= (FRAC_BITS+1)'(((64'd1 << FRAC_BITS) * 64'd999 + 64'd500) / 64'd1000);
      end else if (csr_valid) begin
         unique case (csr_index)
            CFG_OPACITY_CUTOFF: cut_ff <= csr_data[FRAC_BITS-1:0];
            CFG_ALPHA_STOP:     stop_ff <= csr_data;
            default: ;
         endcase
      end
   end
   fbac_front #(.FB(FRAC_BITS), .DB(DEPTH_BITS)) u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .q_valid(qv), .q_pop(qp), .q_data(qd));
   fbac_back #(.FB(FRAC_BITS), .DB(DEPTH_BITS)) u_back (
      .clock, .reset, .cutoff(cut_ff), .stop(stop_ff), .q_valid(qv), .q_pop(qp),
      .q_data(qd), .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));
endmodule
`default_nettype wire

[design/fbac_checker.sv]
// fbac_checker: port-level checks of the compositor, bound to the top level
// depends on no package
`default_nettype none
module fbac_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [100:0] rsp_data,
   input wire logic csr_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp hold");
   a_inv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data[0] |-> rsp_data[100:32] == {51'd0, 1'b1, 17'd0})
      else $error("invalid result not cleared");
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr stalled");
endmodule
bind front_to_back_alpha_compositor_unit fbac_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_data(rsp.data), .csr_ready);
`default_nettype wire
